[rtl/gbfp_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gbfp_pkg
// Types and constants shared by the binary frame parser modules.
// ----------------------------------------------------------------------------
package gbfp_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;
    localparam int unsigned QUEUE_DEPTH = 2;

    localparam logic [CFG_IDX_W-1:0] REG_SYNC_FIRST   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_SECOND  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_PAYLOAD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_POSITION_MSG = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACK_MSG      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NAK_MSG      = 3'd5;

    localparam logic [7:0]  RST_SYNC_FIRST   = 8'd181;
    localparam logic [7:0]  RST_SYNC_SECOND  = 8'd98;
    localparam logic [7:0]  RST_MAX_PAYLOAD  = 8'd200;
    localparam logic [15:0] RST_POSITION_MSG = 16'd1793;
    localparam logic [15:0] RST_ACK_MSG      = 16'd261;
    localparam logic [15:0] RST_NAK_MSG      = 16'd5;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_CK_A     = 2'd1;
    localparam logic [1:0] ERR_CK_B     = 2'd2;
    localparam logic [1:0] ERR_TOO_LONG = 2'd3;

    localparam logic [1:0] ACK_IDLE    = 2'd0;
    localparam logic [1:0] ACK_WAITING = 2'd1;
    localparam logic [1:0] ACK_GOT_ACK = 2'd2;
    localparam logic [1:0] ACK_GOT_NAK = 2'd3;

    typedef enum logic [3:0] {
        PH_SYNC1   = 4'd0,
        PH_SYNC2   = 4'd1,
        PH_CLASS   = 4'd2,
        PH_ID      = 4'd3,
        PH_LEN1    = 4'd4,
        PH_LEN2    = 4'd5,
        PH_PAYLOAD = 4'd6,
        PH_CK1     = 4'd7,
        PH_CK2     = 4'd8
    } phase_t;

    typedef enum logic {
        KIND_RX_BYTE   = 1'b0,
        KIND_ACK_WRITE = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] rx_byte;
        logic [1:0] ack_value;
    } item_t;

    typedef struct packed {
        logic [7:0]  sync_first;
        logic [7:0]  sync_second;
        logic [7:0]  max_payload;
        logic [15:0] position_msg;
        logic [15:0] ack_msg;
        logic [15:0] nak_msg;
    } cfg_t;

    typedef struct packed {
        logic        payload_valid;
        logic [7:0]  payload_byte;
        logic [7:0]  payload_index;
        logic        frame_ok;
        logic        frame_handled;
        logic [1:0]  error_code;
        logic [15:0] message;
        logic [15:0] frame_length;
        logic [1:0]  ack_state;
        logic        module_seen;
    } result_t;

endpackage
`default_nettype wire

[rtl/gnss_binary_frame_parser.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gnss_binary_frame_parser
// Binary navigation frame parser with payload streaming and ack tracking.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): one transaction per received byte (s_action = 0)
//   or per acknowledge status write (s_action = 1, s_ack_value).
//   Result channel (m_*): exactly one transaction per input transaction, in
//   order, carrying payload pass-through, frame status, error code and the
//   current header, ack status and seen flag.
//   Configuration port (cfg_we, cfg_index, cfg_wdata): sync bytes, payload
//   limit and message codes; write only while the block is idle.
//   Path: an accepted input is written into the queue, then taken by the
//   back end into the result register. Throughput: 1 transaction per cycle
//   while m_ready stays high, set by the frame state update in the back end.
//   Reset: queue and result register empty, parser hunting for the first
//   sync byte, registers at their defaults.
//   Receiver stall: the result register holds; the two-entry queue absorbs
//   input until full, then s_ready drops.
// ----------------------------------------------------------------------------
module gnss_binary_frame_parser
    import gbfp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_action,
    input  wire logic [7:0]            s_rx_byte,
    input  wire logic [1:0]            s_ack_value,
    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_payload_valid,
    output logic [7:0]                 m_payload_byte,
    output logic [7:0]                 m_payload_index,
    output logic                       m_frame_ok,
    output logic                       m_frame_handled,
    output logic [1:0]                 m_error_code,
    output logic [15:0]                m_message,
    output logic [15:0]                m_frame_length,
    output logic [1:0]                 m_ack_state,
    output logic                       m_module_seen
);

    cfg_t    cfg_reg;
    logic    q_valid;
    item_t   q_item;
    logic    q_pop;
    result_t result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.sync_first   <= RST_SYNC_FIRST;
            cfg_reg.sync_second  <= RST_SYNC_SECOND;
            cfg_reg.max_payload  <= RST_MAX_PAYLOAD;
            cfg_reg.position_msg <= RST_POSITION_MSG;
            cfg_reg.ack_msg      <= RST_ACK_MSG;
            cfg_reg.nak_msg      <= RST_NAK_MSG;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SYNC_FIRST:   cfg_reg.sync_first   <= cfg_wdata[7:0];
                REG_SYNC_SECOND:  cfg_reg.sync_second  <= cfg_wdata[7:0];
                REG_MAX_PAYLOAD:  cfg_reg.max_payload  <= cfg_wdata[7:0];
                REG_POSITION_MSG: cfg_reg.position_msg <= cfg_wdata;
                REG_ACK_MSG:      cfg_reg.ack_msg      <= cfg_wdata;
                REG_NAK_MSG:      cfg_reg.nak_msg      <= cfg_wdata;
                default: begin
                    // drop writes to unmapped indexes
                end
            endcase
        end
    end

    gbfp_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_action    (s_action),
        .s_rx_byte   (s_rx_byte),
        .s_ack_value (s_ack_value),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_pop       (q_pop)
    );

    gbfp_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (result)
    );

    assign m_payload_valid = result.payload_valid;
    assign m_payload_byte  = result.payload_byte;
    assign m_payload_index = result.payload_index;
    assign m_frame_ok      = result.frame_ok;
    assign m_frame_handled = result.frame_handled;
    assign m_error_code    = result.error_code;
    assign m_message       = result.message;
    assign m_frame_length  = result.frame_length;
    assign m_ack_state     = result.ack_state;
    assign m_module_seen   = result.module_seen;

endmodule
`default_nettype wire

[rtl/gbfp_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gbfp_front
// Accepts input transactions, tags each as a received byte or an acknowledge
// status write, and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module gbfp_front
    import gbfp_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic       s_action,
    input  wire logic [7:0] s_rx_byte,
    input  wire logic [1:0] s_ack_value,
    output logic            q_valid,
    output item_t           q_item,
    input  wire logic       q_pop
);

    localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
    localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push;
    logic              pop;
    item_t             in_item;

    assign s_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready;
    assign q_valid = (count_reg != '0);
    assign pop     = q_pop && q_valid;
    assign q_item  = entry_reg[rd_ptr_reg];

    always_comb begin
        in_item.kind      = s_action ? KIND_ACK_WRITE : KIND_RX_BYTE;
        in_item.rx_byte   = s_rx_byte;
        in_item.ack_value = s_ack_value;
    end

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule
`default_nettype wire

[rtl/gbfp_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gbfp_back
// Frame state machine: sync hunt, header capture, payload pass-through,
// Fletcher checksum check and message handling, with a result register.
// ----------------------------------------------------------------------------
module gbfp_back
    import gbfp_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire cfg_t  cfg,
    input  wire logic  q_valid,
    input  wire item_t q_item,
    output logic       q_pop,
    output logic       m_valid,
    input  wire logic  m_ready,
    output result_t    m_result
);

    phase_t      phase_reg, phase_next;
    logic [7:0]  sum_a_reg, sum_a_next;
    logic [7:0]  sum_b_reg, sum_b_next;
    logic [15:0] message_reg, message_next;
    logic [15:0] length_reg, length_next;
    logic [8:0]  count_reg, count_next;
    logic [1:0]  ack_reg, ack_next;
    logic        seen_reg, seen_next;
    logic        out_valid_reg;
    result_t     out_reg, res;

    logic        take;
    logic [7:0]  b;
    logic [7:0]  fold_a;
    logic [7:0]  fold_b;
    logic [8:0]  count_inc;

    // Advance when the result register is empty or being drained
    assign take     = q_valid && (!out_valid_reg || m_ready);
    assign q_pop    = take;
    assign m_valid  = out_valid_reg;
    assign m_result = out_reg;

    assign b         = q_item.rx_byte;
    assign fold_a    = sum_a_reg + b;
    assign fold_b    = sum_b_reg + fold_a;
    assign count_inc = count_reg + 9'd1;

    always_comb begin
        phase_next   = phase_reg;
        sum_a_next   = sum_a_reg;
        sum_b_next   = sum_b_reg;
        message_next = message_reg;
        length_next  = length_reg;
        count_next   = count_reg;
        ack_next     = ack_reg;
        seen_next    = seen_reg;
        res          = '0;

        if (q_item.kind == KIND_ACK_WRITE) begin
            ack_next = q_item.ack_value;
        end else begin
            unique case (phase_reg)
                PH_SYNC1: begin
                    if (b == cfg.sync_first) begin
                        phase_next = PH_SYNC2;
                    end
                end
                PH_SYNC2: begin
                    if (b == cfg.sync_second) begin
                        phase_next  = PH_CLASS;
                        sum_a_next  = '0;
                        sum_b_next  = '0;
                        length_next = '0;
                        count_next  = '0;
                    end else begin
                        phase_next = PH_SYNC1;
                    end
                end
                PH_CLASS: begin
                    sum_a_next   = fold_a;
                    sum_b_next   = fold_b;
                    message_next = {8'd0, b};
                    phase_next   = PH_ID;
                end
                PH_ID: begin
                    sum_a_next   = fold_a;
                    sum_b_next   = fold_b;
                    message_next = {b, message_reg[7:0]};
                    phase_next   = PH_LEN1;
                end
                PH_LEN1: begin
                    sum_a_next  = fold_a;
                    sum_b_next  = fold_b;
                    length_next = {8'd0, b};
                    phase_next  = PH_LEN2;
                end
                PH_LEN2: begin
                    sum_a_next  = fold_a;
                    sum_b_next  = fold_b;
                    length_next = {b, length_reg[7:0]};
                    phase_next  = ({b, length_reg[7:0]} != 16'd0) ? PH_PAYLOAD : PH_CK1;
                end
                PH_PAYLOAD: begin
                    sum_a_next = fold_a;
                    sum_b_next = fold_b;
                    count_next = count_inc;
                    if (count_inc > {1'b0, cfg.max_payload}) begin
                        // drop the frame: payload runs past the limit
                        res.error_code = ERR_TOO_LONG;
                        phase_next     = PH_SYNC1;
                    end else begin
                        res.payload_valid = 1'b1;
                        res.payload_byte  = b;
                        res.payload_index = count_reg[7:0];
                        if ({7'd0, count_inc} >= length_reg) begin
                            phase_next = PH_CK1;
                        end
                    end
                end
                PH_CK1: begin
                    if (sum_a_reg != b) begin
                        res.error_code = ERR_CK_A;
                        phase_next     = PH_SYNC1;
                    end else begin
                        phase_next = PH_CK2;
                    end
                end
                PH_CK2: begin
                    if (sum_b_reg == b) begin
                        res.frame_ok = 1'b1;
                        priority if (message_reg == cfg.position_msg) begin
                            seen_next         = 1'b1;
                            res.frame_handled = 1'b1;
                        end else if (message_reg == cfg.ack_msg) begin
                            if (ack_reg == ACK_WAITING) begin
                                ack_next = ACK_GOT_ACK;
                            end
                            res.frame_handled = 1'b1;
                        end else if (message_reg == cfg.nak_msg) begin
                            if (ack_reg == ACK_WAITING) begin
                                ack_next = ACK_GOT_NAK;
                            end
                            res.frame_handled = 1'b1;
                        end else begin
                            res.frame_handled = 1'b0;
                        end
                    end else begin
                        res.error_code = ERR_CK_B;
                    end
                    phase_next = PH_SYNC1;
                end
                default: begin
                    phase_next = PH_SYNC1;
                end
            endcase
        end

        res.message      = message_next;
        res.frame_length = length_next;
        res.ack_state    = ack_next;
        res.module_seen  = seen_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_SYNC1;
            sum_a_reg     <= '0;
            sum_b_reg     <= '0;
            message_reg   <= '0;
            length_reg    <= '0;
            count_reg     <= '0;
            ack_reg       <= ACK_IDLE;
            seen_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (take) begin
                phase_reg     <= phase_next;
                sum_a_reg     <= sum_a_next;
                sum_b_reg     <= sum_b_next;
                message_reg   <= message_next;
                length_reg    <= length_next;
                count_reg     <= count_next;
                ack_reg       <= ack_next;
                seen_reg      <= seen_next;
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            out_reg <= res;
        end
    end

endmodule
`default_nettype wire

[dv/gbfp_parse_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gbfp_parse_checker
// Watches the byte and result channels of the binary frame parser, keeps its
// own copy of the parser state and registers, and compares every result
// transaction field by field with the predicted one.
// ----------------------------------------------------------------------------
module gbfp_parse_checker
    import gbfp_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_valid,
    input  wire logic                  s_ready,
    input  wire logic                  s_action,
    input  wire logic [7:0]            s_rx_byte,
    input  wire logic [1:0]            s_ack_value,
    input  wire logic                  m_valid,
    input  wire logic                  m_ready,
    input  wire logic                  m_payload_valid,
    input  wire logic [7:0]            m_payload_byte,
    input  wire logic [7:0]            m_payload_index,
    input  wire logic                  m_frame_ok,
    input  wire logic                  m_frame_handled,
    input  wire logic [1:0]            m_error_code,
    input  wire logic [15:0]           m_message,
    input  wire logic [15:0]           m_frame_length,
    input  wire logic [1:0]            m_ack_state,
    input  wire logic                  m_module_seen,
    output int                         results_pending,
    output int                         mismatch_count,
    output int                         results_checked,
    output int                         good_frames,
    output int                         handled_frames,
    output int                         checksum_errors,
    output int                         oversize_drops,
    output int                         payload_bytes
);

    localparam int MAX_PRINTED = 200;

    cfg_t        parser_cfg;
    phase_t      phase;
    logic [7:0]  fletcher_a;
    logic [7:0]  fletcher_b;
    logic [15:0] msg_word;
    logic [15:0] len_word;
    logic [8:0]  payload_count;
    logic [1:0]  ack_status;
    logic        seen_flag;
    result_t     predicted_q [$];

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED)
            $display("[%0t] MISMATCH %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s: got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    function automatic void fold_byte(input logic [7:0] b);
        fletcher_a = fletcher_a + b;
        fletcher_b = fletcher_b + fletcher_a;
    endfunction

    function automatic result_t advance_parser(input kind_t kind, input logic [7:0] b,
                                               input logic [1:0] ack_in);
        result_t    r;
        logic [8:0] next_count;
        r = '0;
        next_count = payload_count + 9'd1;
        if (kind == KIND_ACK_WRITE) begin
            ack_status = ack_in;
        end else begin
            case (phase)
                PH_SYNC1: begin
                    if (b == parser_cfg.sync_first)
                        phase = PH_SYNC2;
                end
                PH_SYNC2: begin
                    // a mismatch drops back to hunting even if b is the first sync
                    if (b == parser_cfg.sync_second) begin
                        phase = PH_CLASS;
                        fletcher_a = '0;
                        fletcher_b = '0;
                        len_word = '0;
                        payload_count = '0;
                    end else begin
                        phase = PH_SYNC1;
                    end
                end
                PH_CLASS: begin
                    fold_byte(b);
                    msg_word = {8'h00, b};
                    phase = PH_ID;
                end
                PH_ID: begin
                    fold_byte(b);
                    msg_word[15:8] = b;
                    phase = PH_LEN1;
                end
                PH_LEN1: begin
                    fold_byte(b);
                    len_word = {8'h00, b};
                    phase = PH_LEN2;
                end
                PH_LEN2: begin
                    fold_byte(b);
                    len_word[15:8] = b;
                    phase = (len_word != 16'd0) ? PH_PAYLOAD : PH_CK1;
                end
                PH_PAYLOAD: begin
                    fold_byte(b);
                    if (next_count > {1'b0, parser_cfg.max_payload}) begin
                        r.error_code = ERR_TOO_LONG;
                        payload_count = next_count;
                        phase = PH_SYNC1;
                    end else begin
                        r.payload_valid = 1'b1;
                        r.payload_byte = b;
                        r.payload_index = payload_count[7:0];
                        payload_count = next_count;
                        if ({7'd0, payload_count} >= len_word)
                            phase = PH_CK1;
                    end
                end
                PH_CK1: begin
                    if (fletcher_a != b) begin
                        r.error_code = ERR_CK_A;
                        phase = PH_SYNC1;
                    end else begin
                        phase = PH_CK2;
                    end
                end
                PH_CK2: begin
                    if (fletcher_b == b) begin
                        r.frame_ok = 1'b1;
                        // position wins over ack, ack over nak
                        if (msg_word == parser_cfg.position_msg) begin
                            seen_flag = 1'b1;
                            r.frame_handled = 1'b1;
                        end else if (msg_word == parser_cfg.ack_msg) begin
                            if (ack_status == ACK_WAITING)
                                ack_status = ACK_GOT_ACK;
                            r.frame_handled = 1'b1;
                        end else if (msg_word == parser_cfg.nak_msg) begin
                            if (ack_status == ACK_WAITING)
                                ack_status = ACK_GOT_NAK;
                            r.frame_handled = 1'b1;
                        end
                    end else begin
                        r.error_code = ERR_CK_B;
                    end
                    phase = PH_SYNC1;
                end
                default: phase = PH_SYNC1;
            endcase
        end
        r.message = msg_word;
        r.frame_length = len_word;
        r.ack_state = ack_status;
        r.module_seen = seen_flag;
        return r;
    endfunction

    always @(posedge aclk) begin : monitor
        result_t got;
        result_t want;
        if (!aresetn) begin
            parser_cfg = '{RST_SYNC_FIRST, RST_SYNC_SECOND, RST_MAX_PAYLOAD,
                           RST_POSITION_MSG, RST_ACK_MSG, RST_NAK_MSG};
            phase = PH_SYNC1;
            fletcher_a = '0;
            fletcher_b = '0;
            msg_word = '0;
            len_word = '0;
            payload_count = '0;
            ack_status = ACK_IDLE;
            seen_flag = 1'b0;
            predicted_q.delete();
            results_pending <= 0;
        end else begin
            // compare before push: a result never belongs to a byte taken this edge
            if (m_valid && m_ready) begin
                got = {m_payload_valid, m_payload_byte, m_payload_index, m_frame_ok,
                       m_frame_handled, m_error_code, m_message, m_frame_length,
                       m_ack_state, m_module_seen};
                if (predicted_q.size() == 0) begin
                    report_mismatch("result transaction with none outstanding");
                end else begin
                    want = predicted_q.pop_front();
                    check_field("payload_valid", got.payload_valid, want.payload_valid);
                    check_field("payload_byte", got.payload_byte, want.payload_byte);
                    check_field("payload_index", got.payload_index, want.payload_index);
                    check_field("frame_ok", got.frame_ok, want.frame_ok);
                    check_field("frame_handled", got.frame_handled, want.frame_handled);
                    check_field("error_code", got.error_code, want.error_code);
                    check_field("message", got.message, want.message);
                    check_field("frame_length", got.frame_length, want.frame_length);
                    check_field("ack_state", got.ack_state, want.ack_state);
                    check_field("module_seen", got.module_seen, want.module_seen);
                    results_checked++;
                    if (want.frame_ok)
                        good_frames++;
                    if (want.frame_handled)
                        handled_frames++;
                    if (want.error_code == ERR_CK_A || want.error_code == ERR_CK_B)
                        checksum_errors++;
                    if (want.error_code == ERR_TOO_LONG)
                        oversize_drops++;
                    if (want.payload_valid)
                        payload_bytes++;
                end
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_SYNC_FIRST:   parser_cfg.sync_first = cfg_wdata[7:0];
                    REG_SYNC_SECOND:  parser_cfg.sync_second = cfg_wdata[7:0];
                    REG_MAX_PAYLOAD:  parser_cfg.max_payload = cfg_wdata[7:0];
                    REG_POSITION_MSG: parser_cfg.position_msg = cfg_wdata;
                    REG_ACK_MSG:      parser_cfg.ack_msg = cfg_wdata;
                    REG_NAK_MSG:      parser_cfg.nak_msg = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_valid && s_ready)
                predicted_q.push_back(advance_parser(kind_t'(s_action), s_rx_byte, s_ack_value));
            results_pending <= predicted_q.size();
        end
    end

endmodule

[dv/gnss_binary_frame_parser_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gnss_binary_frame_parser_tb
// Feeds the frame parser with well-formed, corrupted, cut and oversize frames,
// line noise and acknowledge writes under five register settings, with bursty
// input and a stalling result side; the checker predicts and compares.
// ----------------------------------------------------------------------------
module gnss_binary_frame_parser_tb;
    import gbfp_pkg::*;

    localparam int CYCLE_LIMIT     = 400000;
    localparam int HOLD_OFF_CYCLES = 120;
    localparam int RANDOM_ITEMS    = 1450;
    localparam int PHASES          = 5;

    typedef enum int {
        FAULT_NONE,
        FAULT_CK_A,
        FAULT_CK_B,
        FAULT_SYNC2,
        FAULT_CUT,
        FAULT_OVERSIZE
    } frame_fault_t;

    logic                  aclk        = 1'b0;
    logic                  aresetn     = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata   = '0;
    logic                  s_valid     = 1'b0;
    logic                  s_ready;
    logic                  s_action    = 1'b0;
    logic [7:0]            s_rx_byte   = '0;
    logic [1:0]            s_ack_value = '0;
    logic                  m_valid;
    logic                  m_ready     = 1'b0;
    logic                  m_payload_valid;
    logic [7:0]            m_payload_byte;
    logic [7:0]            m_payload_index;
    logic                  m_frame_ok;
    logic                  m_frame_handled;
    logic [1:0]            m_error_code;
    logic [15:0]           m_message;
    logic [15:0]           m_frame_length;
    logic [1:0]            m_ack_state;
    logic                  m_module_seen;

    int results_pending;
    int mismatch_count;
    int results_checked;
    int good_frames;
    int handled_frames;
    int checksum_errors;
    int oversize_drops;
    int payload_bytes;

    int          burst_left   = 0;
    int          items_sent   = 0;
    logic        hold_off_req = 1'b0;
    int unsigned cycle_count  = 0;
    cfg_t        cur_cfg;

    gnss_binary_frame_parser dut (.*);

    gbfp_parse_checker u_check (.*);

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding",
                     CYCLE_LIMIT, results_pending);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Result side: random stall patterns, plus long hold-offs on request
    initial begin : result_sink
        int mode;
        int left;
        int hold;
        mode = 0;
        left = 0;
        forever begin
            @(posedge aclk);
            if (hold_off_req) begin
                m_ready <= 1'b0;
                hold = 0;
                while (hold < HOLD_OFF_CYCLES) begin
                    @(posedge aclk);
                    hold++;
                end
                hold_off_req = 1'b0;
            end
            if (left == 0) begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(8, 80);
            end
            left--;
            case (mode)
                0:       m_ready <= 1'b1;
                1:       m_ready <= ($urandom_range(0, 1) == 1);
                2:       m_ready <= ($urandom_range(0, 3) == 0);
                default: m_ready <= (left % 4 != 0);
            endcase
        end
    end

    // Offer one transaction and hold it until accepted; gaps fall between bursts
    task automatic send_item(input kind_t kind, input logic [7:0] rx, input logic [1:0] ackv);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 48);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_action <= kind;
        s_rx_byte <= rx;
        s_ack_value <= ackv;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        burst_left = 0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
    endtask

    // Write every register, one per edge, while the parser is idle
    task automatic apply_settings(input cfg_t c);
        cur_cfg = c;
        cfg_we <= 1'b1;
        cfg_index <= REG_SYNC_FIRST;
        cfg_wdata <= {8'h00, c.sync_first};
        @(posedge aclk);
        cfg_index <= REG_SYNC_SECOND;
        cfg_wdata <= {8'h00, c.sync_second};
        @(posedge aclk);
        cfg_index <= REG_MAX_PAYLOAD;
        cfg_wdata <= {8'h00, c.max_payload};
        @(posedge aclk);
        cfg_index <= REG_POSITION_MSG;
        cfg_wdata <= c.position_msg;
        @(posedge aclk);
        cfg_index <= REG_ACK_MSG;
        cfg_wdata <= c.ack_msg;
        @(posedge aclk);
        cfg_index <= REG_NAK_MSG;
        cfg_wdata <= c.nak_msg;
        @(posedge aclk);
        cfg_we <= 1'b0;
    endtask

    task automatic send_frame(input logic [15:0] code, input int len,
                              input frame_fault_t fault, input bit mix_acks);
        logic [7:0]  frame_q [$];
        logic [7:0]  fa;
        logic [7:0]  fb;
        logic [7:0]  b;
        logic [31:0] hdr;
        int          n_pay;
        int          keep;
        frame_q = {};
        fa = '0;
        fb = '0;
        hdr = {16'(len), code};
        frame_q.push_back(cur_cfg.sync_first);
        if (fault == FAULT_SYNC2) begin
            if (cur_cfg.sync_first != cur_cfg.sync_second && $urandom_range(0, 1) == 1)
                b = cur_cfg.sync_first;
            else
                b = cur_cfg.sync_second ^ 8'($urandom_range(1, 255));
            frame_q.push_back(b);
        end else begin
            frame_q.push_back(cur_cfg.sync_second);
        end
        for (int i = 0; i < 4; i++) begin
            b = hdr[8*i +: 8];
            frame_q.push_back(b);
            fa = fa + b;
            fb = fb + fa;
        end
        n_pay = (fault == FAULT_OVERSIZE) ? int'(cur_cfg.max_payload) + 1 : len;
        for (int i = 0; i < n_pay; i++) begin
            b = 8'($urandom);
            frame_q.push_back(b);
            fa = fa + b;
            fb = fb + fa;
        end
        if (fault != FAULT_OVERSIZE) begin
            frame_q.push_back((fault == FAULT_CK_A) ? fa ^ 8'($urandom_range(1, 255)) : fa);
            frame_q.push_back((fault == FAULT_CK_B) ? fb ^ 8'($urandom_range(1, 255)) : fb);
        end
        if (fault == FAULT_CUT) begin
            keep = $urandom_range(3, frame_q.size() - 1);
            while (frame_q.size() > keep) void'(frame_q.pop_back());
        end
        foreach (frame_q[i]) begin
            // status writes must not disturb the parse in progress
            if (mix_acks && $urandom_range(0, 39) == 0)
                send_item(KIND_ACK_WRITE, 8'($urandom), 2'($urandom));
            send_item(KIND_RX_BYTE, frame_q[i], 2'($urandom));
        end
    endtask

    task automatic random_step();
        int           pick;
        int           len;
        int           lim;
        logic [15:0]  code;
        frame_fault_t fault;
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
            repeat ($urandom_range(1, 6))
                send_item(KIND_RX_BYTE,
                          ($urandom_range(0, 3) == 0) ? cur_cfg.sync_first : 8'($urandom),
                          2'($urandom));
        end else if (pick < 14) begin
            send_item(KIND_ACK_WRITE, 8'($urandom), 2'($urandom));
        end else begin
            case ($urandom_range(0, 4))
                0:       code = cur_cfg.position_msg;
                1:       code = cur_cfg.ack_msg;
                2:       code = cur_cfg.nak_msg;
                default: code = 16'($urandom);
            endcase
            // arm the status first so ack/nak frames resolve it
            if ((code == cur_cfg.ack_msg || code == cur_cfg.nak_msg) &&
                $urandom_range(0, 9) < 6)
                send_item(KIND_ACK_WRITE, 8'($urandom), ACK_WAITING);
            pick = $urandom_range(0, 99);
            if (pick < 60)      fault = FAULT_NONE;
            else if (pick < 68) fault = FAULT_CK_A;
            else if (pick < 76) fault = FAULT_CK_B;
            else if (pick < 84) fault = FAULT_SYNC2;
            else if (pick < 92) fault = FAULT_CUT;
            else                fault = FAULT_OVERSIZE;
            if (fault == FAULT_OVERSIZE && cur_cfg.max_payload > 64 &&
                $urandom_range(0, 3) != 0)
                fault = FAULT_NONE;
            lim = cur_cfg.max_payload;
            if (lim > 8 && $urandom_range(0, 99) < 85)
                lim = 8;
            if (fault == FAULT_OVERSIZE)
                len = ($urandom_range(0, 1) == 1) ? int'(cur_cfg.max_payload) + 1
                                                  : $urandom_range(cur_cfg.max_payload + 1, 65535);
            else
                len = $urandom_range(0, lim);
            send_frame(code, len, fault, 1'b1);
        end
    endtask

    initial begin : stimulus
        cfg_t setting;
        int   phase_end;
        cur_cfg = '{RST_SYNC_FIRST, RST_SYNC_SECOND, RST_MAX_PAYLOAD,
                    RST_POSITION_MSG, RST_ACK_MSG, RST_NAK_MSG};
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: status writes, sync handling, an ack and a position frame
        send_item(KIND_ACK_WRITE, 8'hFF, ACK_GOT_NAK);
        send_item(KIND_ACK_WRITE, 8'h00, ACK_IDLE);
        send_item(KIND_RX_BYTE, cur_cfg.sync_first, 2'b11);
        // repeated first sync byte in the second sync slot drops the hunt
        send_item(KIND_RX_BYTE, cur_cfg.sync_first, 2'b00);
        send_item(KIND_RX_BYTE, 8'h00, 2'b10);
        send_item(KIND_RX_BYTE, 8'hFF, 2'b01);
        send_item(KIND_ACK_WRITE, 8'h5A, ACK_WAITING);
        send_frame(cur_cfg.ack_msg, 0, FAULT_NONE, 1'b0);
        send_frame(cur_cfg.position_msg, 1, FAULT_NONE, 1'b0);

        for (int ph = 0; ph < PHASES; ph++) begin
            if (ph > 0) begin
                wait_drained();
                case (ph)
                    1: setting = '{8'h00, 8'hFF, 8'd0, 16'hFFFF, 16'h0000, 16'hFFFF};
                    2: setting = '{8'hFF, 8'h00, 8'd255, 16'h0000, 16'h0105, 16'h0105};
                    3: begin
                        setting.sync_first = 8'($urandom);
                        setting.sync_second = 8'($urandom);
                        setting.max_payload = 8'($urandom_range(4, 40));
                        setting.position_msg = 16'($urandom);
                        setting.ack_msg = 16'($urandom);
                        setting.nak_msg = 16'($urandom);
                    end
                    default: begin
                        setting = '{RST_SYNC_FIRST, RST_SYNC_SECOND, 8'd12,
                                    RST_POSITION_MSG, RST_ACK_MSG, RST_NAK_MSG};
                        setting.sync_first = 8'($urandom);
                        setting.sync_second = setting.sync_first;
                    end
                endcase
                apply_settings(setting);
            end
            // keep offering while the result side holds off
            if (ph == 2 || ph == 4)
                hold_off_req = 1'b1;
            phase_end = items_sent + RANDOM_ITEMS / PHASES;
            while (items_sent < phase_end) begin
                random_step();
                if ($urandom_range(0, 149) == 0)
                    wait_drained();
            end
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        $display("Sent %0d byte and status transactions over %0d register settings; %0d results checked",
                 items_sent, PHASES, results_checked);
        $display("Frames: %0d good, %0d handled, %0d checksum errors, %0d oversize drops; %0d payload bytes",
                 good_frames, handled_frames, checksum_errors, oversize_drops, payload_bytes);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
